@@ design/gds_pkg.sv @@
package gds_pkg;

    // Sizing
    localparam int MAX_GRID    = 32;
    localparam int AMOUNT_BITS = 32;
    localparam int GAIN_W      = 14;
    localparam int DIM_W       = 6;
    localparam int DIM_MIN     = 2;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = $clog2(MAX_GRID);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;

    // Arithmetic widths: four-term sums, signed differences, gain products
    localparam int SUM_W  = AMOUNT_BITS + 2;
    localparam int DIFF_W = AMOUNT_BITS + 3;
    localparam int PROD_W = DIFF_W + GAIN_W;
    localparam int TOT_W  = PROD_W + 1;

    // Register reset values
    localparam logic [GAIN_W-1:0] ORTH_GAIN_RST = 14'd3277;
    localparam logic [GAIN_W-1:0] DIAG_GAIN_RST = 14'd2317;
    localparam logic [DIM_W-1:0]  DIM_RST       = 6'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORTH_GAIN,
        CFG_DIAG_GAIN,
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_INPUT,
        SEQ_EDGE,
        SEQ_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic [AMOUNT_BITS-1:0] cell_amount;
        logic                   frame_start;
    } cell_in_t;

    typedef struct packed {
        logic [AMOUNT_BITS-1:0] new_amount;
        logic [POS_W-1:0]       out_row;
        logic [POS_W-1:0]       out_column;
        logic                   last_of_run;
        logic                   frame_done;
    } cell_out_t;

    // One window step: the column entering the 3x3 window
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             store;
        logic             run_end;
        logic             done;
    } step_t;

    // Position and flags of the cell being computed
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_end;
        logic             done;
    } tag_t;

    // Centre of the window plus which neighbours lie inside the grid
    typedef struct packed {
        tag_t tag;
        logic up;
        logic down;
        logic left;
        logic right;
    } centre_t;

endpackage

@@ design/grid_diffusion_stencil_step_core.sv @@
// Three-by-three diffusion stencil over a raster stream of grid cells.
//
// Channels: cell_valid/cell_ready/cell_in take one cell amount per transaction
// in raster order; frame_start puts the cell at row 0, column 0.
// result_valid/result_ready/result give the next-step amounts with their
// row and column; last_of_run closes the results of one input transaction
// and frame_done marks the grid's last cell. cfg_we/cfg_index/cfg_data write
// the gains and the grid size (a size write also rewinds to row 0, col 0).
//
// Throughput: one cell per cycle while cell_ready is high. A cell that ends a
// row (row 1 onwards) is followed by a right-hand border column, and the
// grid's last cell also by the bottom border row while the last row is
// flushed; cell_ready is low while these border steps issue. The line store
// has one read and one write port, so window columns pass one per cycle.
// Cell (r, c) releases the result for (r-1, c-1) via the stage 1, window,
// difference, product and result registers; row 0 results wait for row 1.
// Stall: every stage holds its contents while the next is full, so with
// result_ready low the block still takes cells until the pipe is full.
// Reset: gains and size return to defaults, position to row 0, col 0, pipe
// empty. The line store is not cleared; only entries of the current frame
// are ever used.
module grid_diffusion_stencil_step_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cell_valid,
    output logic                            cell_ready,
    input  gds_pkg::cell_in_t               cell_in,
    output logic                            result_valid,
    input  logic                            result_ready,
    output gds_pkg::cell_out_t              result,
    input  logic                            cfg_we,
    input  logic [gds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gds_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gds_pkg::*;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        if (d < DIM_W'(DIM_MIN))
            c = DIM_W'(DIM_MIN);
        else if (d > DIM_W'(MAX_GRID))
            c = DIM_W'(MAX_GRID);
        else
            c = d;
        return c;
    endfunction

    // Value times a neighbour count of 0..4, by shift and add
    function automatic logic [SUM_W-1:0] times_count(input logic [AMOUNT_BITS-1:0] v,
                                                     input logic [2:0] n);
        logic [SUM_W-1:0] ve;
        ve = SUM_W'(v);
        return (n[2] ? (ve << 2) : '0) + (n[1] ? (ve << 1) : '0) + (n[0] ? ve : '0);
    endfunction

    // ------------------------------------------------------------------
    // Configuration; sizes are held already clamped
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] orth_gain_reg, diag_gain_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic              dim_write;

    assign dim_write = cfg_we && (cfg_idx_t'(cfg_index) == CFG_GRID_WIDTH ||
                                  cfg_idx_t'(cfg_index) == CFG_GRID_HEIGHT);

    // ------------------------------------------------------------------
    // Sequencer: turns cells into window steps. Besides the real column of
    // each cell it issues a border column at row end (col = width) and a
    // border row at frame end (row = height, cols 0..width).
    // ------------------------------------------------------------------
    seq_state_t       state_reg, state_next;
    logic [POS_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [DIM_W-1:0] edge_row_reg, edge_row_next;
    logic [DIM_W-1:0] flush_col_reg, flush_col_next;
    logic             flush_pending_reg, flush_pending_next;

    logic [POS_W-1:0] cur_row, cur_col;
    logic             cur_last_row, cur_last_col, need_edge;
    logic             issue_valid, issue_fire;
    step_t            issue_step;

    // Pipeline handshake
    logic o_ready, p_ready, d_ready, w_ready, s1_ready, s1_move;

    // Position of the arriving cell
    always_comb
    begin
        cur_row = cell_in.frame_start ? '0 : row_reg;
        cur_col = cell_in.frame_start ? '0 : col_reg;
        if (DIM_W'(cur_row) >= height_reg)
            cur_row = '0;
        if (DIM_W'(cur_col) >= width_reg)
            cur_col = '0;
        cur_last_row = DIM_W'(cur_row) == height_reg - DIM_W'(1);
        cur_last_col = DIM_W'(cur_col) == width_reg - DIM_W'(1);
        need_edge    = (cur_row != '0) && cur_last_col;
    end

    // Next state
    always_comb
    begin
        state_next         = state_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        edge_row_next      = edge_row_reg;
        flush_pending_next = flush_pending_reg;
        flush_col_next     = flush_col_reg;
        case (state_reg)
            SEQ_INPUT:
            begin
                if (issue_fire)
                begin
                    if (DIM_W'(cur_col) + DIM_W'(1) >= width_reg)
                    begin
                        col_next = '0;
                        row_next = (DIM_W'(cur_row) + DIM_W'(1) >= height_reg) ?
                                   '0 : cur_row + POS_W'(1);
                    end
                    else
                    begin
                        row_next = cur_row;
                        col_next = cur_col + POS_W'(1);
                    end
                    edge_row_next      = DIM_W'(cur_row);
                    flush_pending_next = cur_last_row && cur_last_col;
                    if (need_edge)
                        state_next = SEQ_EDGE;
                end
            end
            SEQ_EDGE:
            begin
                if (issue_fire)
                begin
                    if (flush_pending_reg)
                    begin
                        state_next     = SEQ_FLUSH;
                        flush_col_next = '0;
                    end
                    else
                        state_next = SEQ_INPUT;
                end
            end
            SEQ_FLUSH:
            begin
                if (issue_fire)
                begin
                    if (flush_col_reg == width_reg)
                        state_next = SEQ_INPUT;
                    else
                        flush_col_next = flush_col_reg + DIM_W'(1);
                end
            end
            default:
                state_next = SEQ_INPUT;
        endcase
        if (dim_write)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    // Sequencer outputs
    always_comb
    begin
        issue_valid = 1'b0;
        issue_step  = '0;
        case (state_reg)
            SEQ_INPUT:
            begin
                issue_valid        = cell_valid;
                issue_step.row     = DIM_W'(cur_row);
                issue_step.col     = DIM_W'(cur_col);
                issue_step.store   = 1'b1;
                issue_step.run_end = !need_edge;
            end
            SEQ_EDGE:
            begin
                issue_valid        = 1'b1;
                issue_step.row     = edge_row_reg;
                issue_step.col     = width_reg;
                issue_step.run_end = !flush_pending_reg;
            end
            SEQ_FLUSH:
            begin
                issue_valid        = 1'b1;
                issue_step.row     = height_reg;
                issue_step.col     = flush_col_reg;
                issue_step.run_end = flush_col_reg == width_reg;
                issue_step.done    = flush_col_reg == width_reg;
            end
            default:
                issue_valid = 1'b0;
        endcase
    end

    assign cell_ready = (state_reg == SEQ_INPUT) && s1_ready;
    assign issue_fire = issue_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orth_gain_reg     <= ORTH_GAIN_RST;
            diag_gain_reg     <= DIAG_GAIN_RST;
            width_reg         <= DIM_RST;
            height_reg        <= DIM_RST;
            state_reg         <= SEQ_INPUT;
            row_reg           <= '0;
            col_reg           <= '0;
            edge_row_reg      <= '0;
            flush_pending_reg <= 1'b0;
            flush_col_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ORTH_GAIN:   orth_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_DIAG_GAIN:   diag_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_GRID_WIDTH:  width_reg     <= clamp_dim(cfg_data[DIM_W-1:0]);
                    CFG_GRID_HEIGHT: height_reg    <= clamp_dim(cfg_data[DIM_W-1:0]);
                    default:         orth_gain_reg <= orth_gain_reg;
                endcase
            end
            state_reg         <= state_next;
            row_reg           <= row_next;
            col_reg           <= col_next;
            edge_row_reg      <= edge_row_next;
            flush_pending_reg <= flush_pending_next;
            flush_col_reg     <= flush_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Ready chain: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, w_valid_reg, d_valid_reg, p_valid_reg, result_valid_reg;

    assign o_ready  = !result_valid_reg || result_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign d_ready  = !d_valid_reg || p_ready;
    assign w_ready  = !w_valid_reg || d_ready;
    assign s1_ready = !s1_valid_reg || w_ready;
    assign s1_move  = s1_valid_reg && w_ready;

    // ------------------------------------------------------------------
    // Line store: one entry per column, {row r-2, row r-1}. Read at issue,
    // written back as {row r-1, row r} when the step leaves stage 1.
    // ------------------------------------------------------------------
    logic [2*AMOUNT_BITS-1:0] line_mem [MAX_GRID];
    logic [2*AMOUNT_BITS-1:0] rd_reg;
    step_t                    s1_step_reg;
    logic [AMOUNT_BITS-1:0]   s1_amount_reg;

    always_ff @(posedge clk)
    begin
        if (issue_fire && (issue_step.col < width_reg))
            rd_reg <= line_mem[issue_step.col[POS_W-1:0]];
        if (s1_move && s1_step_reg.store)
            line_mem[s1_step_reg.col[POS_W-1:0]] <= {rd_reg[AMOUNT_BITS-1:0], s1_amount_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= issue_valid;
    end

    always_ff @(posedge clk)
    begin
        if (issue_fire)
        begin
            s1_step_reg   <= issue_step;
            s1_amount_reg <= cell_in.cell_amount;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window: [0] oldest row .. [2] newest row; [.][1] is the centre
    // ------------------------------------------------------------------
    logic [AMOUNT_BITS-1:0] win_reg [3][3];
    centre_t                centre_reg, centre_next;
    logic                   s1_emit;

    assign s1_emit = (s1_step_reg.row != '0) && (s1_step_reg.col != '0);

    always_comb
    begin
        centre_next.tag.row     = POS_W'(s1_step_reg.row - DIM_W'(1));
        centre_next.tag.col     = POS_W'(s1_step_reg.col - DIM_W'(1));
        centre_next.tag.run_end = s1_step_reg.run_end;
        centre_next.tag.done    = s1_step_reg.done;
        centre_next.up          = s1_step_reg.row >= DIM_W'(2);
        centre_next.down        = s1_step_reg.row < height_reg;
        centre_next.left        = s1_step_reg.col >= DIM_W'(2);
        centre_next.right       = s1_step_reg.col < width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (w_ready)
            w_valid_reg <= s1_move && s1_emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_reg[2*AMOUNT_BITS-1:AMOUNT_BITS];
            win_reg[1][2] <= rd_reg[AMOUNT_BITS-1:0];
            win_reg[2][2] <= s1_amount_reg;
            centre_reg    <= centre_next;
        end
    end

    // ------------------------------------------------------------------
    // Differences: So - no*v and Sd - nd*v
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]          sum_o, sum_d;
    logic [2:0]                cnt_o, cnt_d;
    logic signed [DIFF_W-1:0]  diff_o, diff_d;
    logic signed [DIFF_W-1:0]  d_o_reg, d_d_reg;
    logic [AMOUNT_BITS-1:0]    d_v_reg;
    tag_t                      d_tag_reg;

    always_comb
    begin
        sum_o = SUM_W'(centre_reg.up    ? win_reg[0][1] : '0)
              + SUM_W'(centre_reg.down  ? win_reg[2][1] : '0)
              + SUM_W'(centre_reg.left  ? win_reg[1][0] : '0)
              + SUM_W'(centre_reg.right ? win_reg[1][2] : '0);
        sum_d = SUM_W'((centre_reg.up   && centre_reg.left)  ? win_reg[0][0] : '0)
              + SUM_W'((centre_reg.up   && centre_reg.right) ? win_reg[0][2] : '0)
              + SUM_W'((centre_reg.down && centre_reg.left)  ? win_reg[2][0] : '0)
              + SUM_W'((centre_reg.down && centre_reg.right) ? win_reg[2][2] : '0);
        cnt_o = 3'(centre_reg.up) + 3'(centre_reg.down)
              + 3'(centre_reg.left) + 3'(centre_reg.right);
        cnt_d = 3'(centre_reg.up && centre_reg.left) + 3'(centre_reg.up && centre_reg.right)
              + 3'(centre_reg.down && centre_reg.left) + 3'(centre_reg.down && centre_reg.right);
        diff_o = $signed(DIFF_W'(sum_o)) - $signed(DIFF_W'(times_count(win_reg[1][1], cnt_o)));
        diff_d = $signed(DIFF_W'(sum_d)) - $signed(DIFF_W'(times_count(win_reg[1][1], cnt_d)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (d_ready)
            d_valid_reg <= w_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (w_valid_reg && d_ready)
        begin
            d_o_reg   <= diff_o;
            d_d_reg   <= diff_d;
            d_v_reg   <= win_reg[1][1];
            d_tag_reg <= centre_reg.tag;
        end
    end

    // ------------------------------------------------------------------
    // Gain products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p_o_reg, p_d_reg;
    logic [AMOUNT_BITS-1:0]   p_v_reg;
    tag_t                     p_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (p_ready)
            p_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_valid_reg && p_ready)
        begin
            p_o_reg   <= PROD_W'(signed'({1'b0, orth_gain_reg})) * PROD_W'(d_o_reg);
            p_d_reg   <= PROD_W'(signed'({1'b0, diag_gain_reg})) * PROD_W'(d_d_reg);
            p_v_reg   <= d_v_reg;
            p_tag_reg <= d_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Floor shift, add to the centre, saturate; result register
    // ------------------------------------------------------------------
    logic signed [TOT_W-1:0] total, amount;
    logic [AMOUNT_BITS-1:0]  amount_sat;
    cell_out_t               result_reg;

    always_comb
    begin
        total  = TOT_W'(p_o_reg) + TOT_W'(p_d_reg);
        amount = (total >>> FRAC_BITS) + $signed(TOT_W'(p_v_reg));
        if (amount[TOT_W-1])
            amount_sat = '0;
        else if (|amount[TOT_W-2:AMOUNT_BITS])
            amount_sat = '1;
        else
            amount_sat = amount[AMOUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (o_ready)
            result_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg && o_ready)
        begin
            result_reg.new_amount  <= amount_sat;
            result_reg.out_row     <= p_tag_reg.row;
            result_reg.out_column  <= p_tag_reg.col;
            result_reg.last_of_run <= p_tag_reg.run_end;
            result_reg.frame_done  <= p_tag_reg.done;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ design/gds_checker.sv @@
module gds_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                result_valid,
    input  logic                result_ready,
    input  gds_pkg::cell_out_t  result
);
    import gds_pkg::*;

    // set once the grid's last cell has been taken, until the next result
    logic after_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_done_reg <= 1'b0;
        else if (result_valid && result_ready)
            after_done_reg <= result.frame_done;
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // the grid's last cell always closes its transaction's run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> result.last_of_run)
        else $error("frame_done without last_of_run");

    // last cell of a grid of at least 2x2 is never on row 0 or column 0
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> result.out_row != '0 && result.out_column != '0)
        else $error("frame_done on a border origin cell");

    // a new frame starts its results at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && after_done_reg |-> result.out_row == '0 && result.out_column == '0)
        else $error("first result after frame end not at origin");

endmodule

bind grid_diffusion_stencil_step_core gds_checker u_gds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import gds_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    // random cells, on top of the directed ones
    localparam int ITEMS        = 22;
    // Cells in row 0 give no result, so the pipe may still be busy when the
    // queue empties; wait this long before touching a register.
    localparam int SETTLE       = 12;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [AMOUNT_BITS-1:0] FULL     = '1;
    localparam logic [CFG_DATA_W-1:0]  GAIN_TOP = '1;

    // One row of the directed stimulus: a register write or a cell.
    typedef struct {
        bit                     is_cfg;
        cfg_idx_t               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        cell_in_t               item;
        bit                     fixed;
        logic [AMOUNT_BITS-1:0] fixed_amt;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cell_valid;
    logic                  cell_ready;
    cell_in_t              cell_in;
    logic                  result_valid;
    logic                  result_ready;
    cell_out_t             result_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Own copy of the block's line store, registers and raster position
    logic [AMOUNT_BITS-1:0] grid_rows [3][MAX_GRID];
    logic [GAIN_W-1:0]      orth_gain;
    logic [GAIN_W-1:0]      diag_gain;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    int                     at_row;
    int                     at_col;
    cell_out_t              expected_q[$];

    int        fail_count   = 0;
    int        quiet_cycles = 0;
    int        random_cells = 0;
    bit        steady       = 1'b0;
    bit        drained_once = 1'b0;
    plan_row_t plan[$];

    // Ports in declaration order
    grid_diffusion_stencil_step_core u_top (
        clk, rst_n,
        cell_valid, cell_ready, cell_in,
        result_valid, result_ready, result_out,
        cfg_we, cfg_index, cfg_data
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Mostly short gaps, now and then a long one; none while steady
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int clamp_dim(logic [DIM_W-1:0] d);
        if (d < DIM_MIN)
            return DIM_MIN;
        if (d > MAX_GRID)
            return MAX_GRID;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain(logic [CFG_DATA_W-1:0] dflt);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return GAIN_TOP;
            2:       return dflt;
            default: return $urandom_range(0, GAIN_TOP);
        endcase
    endfunction

    // Out-of-range sizes now and then, to hit the clamps
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(33, 63);
            2:       return MAX_GRID;
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    // Next-step amount of cell (r, c); off-grid neighbours are walls
    function automatic cell_out_t make_result(int r, int c, int h, int w, bit done);
        cell_out_t o;
        longint    centre, orth_sum, diag_sum, flow, nv;
        int        orth_n, diag_n, rr, cc, dr, dc;
        centre   = grid_rows[r % 3][c];
        orth_sum = 0;
        diag_sum = 0;
        orth_n   = 0;
        diag_n   = 0;
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
                begin
                    if (dr == 0 || dc == 0)
                    begin
                        orth_sum += grid_rows[rr % 3][cc];
                        orth_n++;
                    end
                    else
                    begin
                        diag_sum += grid_rows[rr % 3][cc];
                        diag_n++;
                    end
                end
            end
        end
        flow = longint'(orth_gain) * (orth_sum - orth_n * centre)
             + longint'(diag_gain) * (diag_sum - diag_n * centre);
        nv = centre + (flow >>> FRAC_BITS);     // floor, also for a net outflow
        if (nv < 0)
            o.new_amount = '0;
        else if (nv[63:AMOUNT_BITS] != 0)
            o.new_amount = FULL;
        else
            o.new_amount = nv[AMOUNT_BITS-1:0];
        o.out_row     = r[POS_W-1:0];
        o.out_column  = c[POS_W-1:0];
        o.last_of_run = 1'b0;
        o.frame_done  = done;
        return o;
    endfunction

    // Store the accepted cell, queue what it releases, advance the raster position
    task automatic predict_cell(cell_in_t item, bit fixed, logic [AMOUNT_BITS-1:0] fixed_amt);
        cell_out_t run[$];
        int        w, h, r, c, k;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        r = at_row;
        c = at_col;
        if (item.frame_start)
        begin
            r = 0;
            c = 0;
        end
        if (r >= h)
            r = 0;
        if (c >= w)
            c = 0;
        grid_rows[r % 3][c] = item.cell_amount;
        if (r >= 1)
        begin
            if (c >= 1)
                run.push_back(make_result(r - 1, c - 1, h, w, 1'b0));
            if (c == w - 1)
                run.push_back(make_result(r - 1, c, h, w, 1'b0));
        end
        // last cell of the grid flushes the whole bottom row
        if (r == h - 1 && c == w - 1)
            for (k = 0; k < w; k++)
                run.push_back(make_result(r, k, h, w, k == w - 1));
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            c++;
        at_row = r;
        at_col = c;
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
        begin
            if (fixed)
                run[i].new_amount = fixed_amt;
            expected_q.push_back(run[i]);
        end
    endtask

    // Called at a falling edge; returns at a falling edge with valid still high
    task automatic send_cell(cell_in_t item, bit fixed, logic [AMOUNT_BITS-1:0] fixed_amt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_valid <= 1'b1;
        cell_in    <= item;
        do
            @(posedge clk);
        while (!cell_ready);
        predict_cell(item, fixed, fixed_amt);
        @(negedge clk);
    endtask

    // Hold the sender until every queued result is out, then wait out the settle argument
    task automatic wait_idle(int settle);
        cell_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        wait_idle(SETTLE);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ORTH_GAIN:   orth_gain = val[GAIN_W-1:0];
            CFG_DIAG_GAIN:   diag_gain = val[GAIN_W-1:0];
            CFG_GRID_WIDTH:  width_reg = val[DIM_W-1:0];
            CFG_GRID_HEIGHT: height_reg = val[DIM_W-1:0];
            default: ;
        endcase
        // a size write rewinds the raster position
        if (idx == CFG_GRID_WIDTH || idx == CFG_GRID_HEIGHT)
        begin
            at_row = 0;
            at_col = 0;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Styles: random, small, near full, uniform, full/empty mix
    task automatic send_frame(int cells, int style, bit lead_start);
        logic [AMOUNT_BITS-1:0] base, amt;
        bit                     fs;
        int                     k;
        base = $urandom();
        for (k = 0; k < cells; k++)
        begin
            case (style)
                0:       amt = $urandom();
                1:       amt = $urandom_range(0, 32'h0003_FFFF);
                2:       amt = FULL - $urandom_range(0, 32'h0003_FFFF);
                3:       amt = base;
                default: amt = $urandom_range(0, 1) ? FULL : '0;
            endcase
            fs = (k == 0) ? lead_start : ($urandom_range(0, 59) == 0);
            if ((!drained_once && k == cells / 2) || $urandom_range(0, 79) == 0)
            begin
                wait_idle(1);
                drained_once = 1'b1;
            end
            send_cell('{cell_amount: amt, frame_start: fs}, 1'b0, '0);
        end
    endtask

    task automatic random_phase();
        int w, h, frames, cells, f;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1))
            write_reg(CFG_ORTH_GAIN, pick_gain(ORTH_GAIN_RST));
        if ($urandom_range(0, 1))
            write_reg(CFG_DIAG_GAIN, pick_gain(DIAG_GAIN_RST));
        if ($urandom_range(0, 1))
            write_reg(CFG_GRID_WIDTH, pick_dim());
        // new height now and then, and always if the area is above 64; a width above 8 keeps it small
        if ($urandom_range(0, 1) || clamp_dim(width_reg) * clamp_dim(height_reg) > 64)
        begin
            if (clamp_dim(width_reg) > 8)
                write_reg(CFG_GRID_HEIGHT, $urandom_range(0, 3));
            else
                write_reg(CFG_GRID_HEIGHT, pick_dim());
        end
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        frames = $urandom_range(1, 2);
        for (f = 0; f < frames; f++)
        begin
            cells = w * h;
            if ($urandom_range(0, 5) == 0)
                cells = $urandom_range(1, cells - 1);      // frame cut short
            if (cells > ITEMS - random_cells)
                cells = ITEMS - random_cells;
            if (cells > 0)
            begin
                send_frame(cells, $urandom_range(0, 4), $urandom_range(0, 4) != 0);
                random_cells += cells;
            end
        end
        steady = 1'b0;
    endtask

    function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t p;
        p.is_cfg    = 1'b1;
        p.reg_idx   = idx;
        p.reg_val   = val;
        p.item      = '0;
        p.fixed     = 1'b0;
        p.fixed_amt = '0;
        return p;
    endfunction

    function automatic plan_row_t cell_row(logic [AMOUNT_BITS-1:0] amt, bit fs,
                                           bit fixed, logic [AMOUNT_BITS-1:0] fixed_amt);
        plan_row_t p;
        p.is_cfg    = 1'b0;
        p.reg_idx   = CFG_ORTH_GAIN;
        p.reg_val   = '0;
        p.item      = '{cell_amount: amt, frame_start: fs};
        p.fixed     = fixed;
        p.fixed_amt = fixed_amt;
        return p;
    endfunction

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Result side: stalls of random length, none while steady
    initial
    begin : result_sink
        int stall;
        stall = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Every result transaction is checked against the oldest expectation
    always @(posedge clk)
    begin : result_check
        cell_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, row %0d col %0d amount %h",
                         $time, result_out.out_row, result_out.out_column,
                         result_out.new_amount);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("new_amount", want.new_amount, result_out.new_amount);
                compare_field("out_row", want.out_row, result_out.out_row);
                compare_field("out_column", want.out_column, result_out.out_column);
                compare_field("last_of_run", want.last_of_run, result_out.last_of_run);
                compare_field("frame_done", want.frame_done, result_out.frame_done);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cell_valid && cell_ready) || (result_valid && result_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles < STALL_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;
        cell_valid = 1'b0;
        cell_in    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ORTH_GAIN;
        cfg_data   = '0;
        foreach (grid_rows[i, j])
            grid_rows[i][j] = '0;
        orth_gain  = ORTH_GAIN_RST;
        diag_gain  = DIAG_GAIN_RST;
        width_reg  = DIM_RST;
        height_reg = DIM_RST;
        at_row     = 0;
        at_col     = 0;

        // 2x2 grid from sizes below the minimum; a uniform grid keeps its value
        plan.push_back(cfg_row(CFG_GRID_WIDTH, 1));
        plan.push_back(cfg_row(CFG_GRID_HEIGHT, 0));
        for (k = 0; k < 4; k++)
            plan.push_back(cell_row(FULL, k == 0, 1'b1, FULL));
        // full gains overshoot: a hole saturates high, a peak clamps at zero
        plan.push_back(cfg_row(CFG_ORTH_GAIN, GAIN_TOP));
        plan.push_back(cfg_row(CFG_DIAG_GAIN, GAIN_TOP));
        plan.push_back(cfg_row(CFG_GRID_WIDTH, 3));
        plan.push_back(cfg_row(CFG_GRID_HEIGHT, 3));
        // two cells, then a frame start abandons them
        plan.push_back(cell_row(32'h1234_5678, 1'b1, 1'b0, '0));
        plan.push_back(cell_row(32'h8000_0001, 1'b0, 1'b0, '0));
        for (k = 0; k < 9; k++)
            plan.push_back(cell_row((k == 4) ? '0 : FULL, k == 0, 1'b0, '0));
        for (k = 0; k < 9; k++)
            plan.push_back(cell_row((k == 4) ? FULL : '0, k == 0, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_cell(plan[i].item, plan[i].fixed, plan[i].fixed_amt);
        end

        // widest grid, width clamped from above: the last cell releases the most results
        write_reg(CFG_DIAG_GAIN, '0);
        write_reg(CFG_GRID_WIDTH, 63);
        write_reg(CFG_GRID_HEIGHT, 2);
        send_frame(2 * MAX_GRID, 0, 1'b1);

        while (random_cells < ITEMS)
            random_phase();

        wait_idle(SETTLE);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
